### hw/rtl/alr_pkg.sv
package alr_pkg;

    localparam int CUM_W  = 15;
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int BCNT_W = 4;

    localparam logic [KIND_W-1:0] KIND_ENC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RST = 2'd2;

    localparam logic [BCNT_W-1:0] BITS_FULL = 4'd8;
    localparam logic [BCNT_W-1:0] BITS_ONE  = 4'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_REN,
        ST_FOL,
        ST_FIN,
        ST_FINL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic put;
        logic data;
        logic fin;
        logic flush;
        logic clear;
        logic ovf;
    } pack_cmd_t;

endpackage

### hw/rtl/alr_pack.sv
module alr_pack (
    input  logic                         clk,
    input  logic                         rst_n,
    input  alr_pkg::pack_cmd_t           cmd,
    output logic                         taken,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [alr_pkg::BYTE_W-1:0]   out_byte,
    output logic                         last_of_run,
    output logic                         end_of_stream,
    output logic                         follow_overflow
);

    logic [alr_pkg::BYTE_W-1:0] partial_reg, partial_next;
    logic [alr_pkg::BCNT_W-1:0] bits_left_reg, bits_left_next;
    logic                       hold_valid_reg, hold_valid_next;
    logic [alr_pkg::BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic                       hold_eos_reg, hold_eos_next;
    logic                       out_valid_reg, out_valid_next;
    logic [alr_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       last_reg, last_next;
    logic                       eos_reg, eos_next;
    logic                       ovf_reg, ovf_next;

    logic                       blocked;
    logic                       completes;
    logic                       push;
    logic                       move;
    logic [alr_pkg::BYTE_W-1:0] new_byte;

    // The hold stage keeps the newest byte back until it is known whether it closes the run.
    assign blocked   = hold_valid_reg && out_valid_reg && !out_ready;
    assign completes = (cmd.put && (bits_left_reg == alr_pkg::BITS_ONE)) || cmd.fin;
    assign new_byte  = cmd.fin ? (partial_reg >> bits_left_reg)
                               : {cmd.data, partial_reg[alr_pkg::BYTE_W-1:1]};

    always_comb
    begin
        taken = cmd.clear
             || (cmd.put && !(completes && blocked))
             || (cmd.fin && !blocked)
             || (cmd.flush && !blocked);
    end

    assign push = taken && completes;
    assign move = hold_valid_reg && (push || (cmd.flush && taken));

    always_comb
    begin
        partial_next    = partial_reg;
        bits_left_next  = bits_left_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_eos_next   = hold_eos_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;
        eos_next        = eos_reg;
        ovf_next        = ovf_reg;

        if (cmd.clear)
        begin
            partial_next   = '0;
            bits_left_next = alr_pkg::BITS_FULL;
        end
        else if (push)
        begin
            partial_next   = '0;
            bits_left_next = alr_pkg::BITS_FULL;
        end
        else if (cmd.put && taken)
        begin
            partial_next   = new_byte;
            bits_left_next = bits_left_reg - alr_pkg::BITS_ONE;
        end

        if (move)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = hold_byte_reg;
            last_next      = cmd.flush;
            eos_next       = hold_eos_reg;
            ovf_next       = cmd.ovf;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (push)
        begin
            hold_valid_next = 1'b1;
            hold_byte_next  = new_byte;
            hold_eos_next   = cmd.fin;
        end
        else if (move)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg    <= '0;
            bits_left_reg  <= alr_pkg::BITS_FULL;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            partial_reg    <= partial_next;
            bits_left_reg  <= bits_left_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        hold_eos_reg  <= hold_eos_next;
        out_byte_reg  <= out_byte_next;
        last_reg      <= last_next;
        eos_reg       <= eos_next;
        ovf_reg       <= ovf_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign last_of_run     = last_reg;
    assign end_of_stream   = eos_reg;
    assign follow_overflow = ovf_reg;

`ifndef ASSERT_OFF
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && hold_valid_reg) |-> (!out_valid_reg || out_ready))
        else $error("byte pushed while hold and output are both occupied");

    a_bits_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bits_left_reg != '0) && (bits_left_reg <= alr_pkg::BITS_FULL))
        else $error("bit counter out of range");

    a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!eos_reg || last_reg))
        else $error("end of stream byte not marked as last of run");
`endif

endmodule

### hw/rtl/arithmetic_encoder_low_range.sv
// Arithmetic encoder with a CODE_BITS-wide low and range state.
// Input channel (in_valid/in_ready): one beat per item; kind selects encode,
// finish or restart, and the three count fields drive an encode.
// Output channel (out_valid/out_ready): one beat per packed code byte, first
// bit in bit 0; last_of_run marks the final byte of an item, end_of_stream the
// right-aligned byte that closes a finish.
// Items are handled one at a time; in_ready is high while the sequencer idles.
// An encode runs the multiply, the divide and the update, then up to CODE_BITS-1
// renormalisation steps, the follow bits and the release of the held byte;
// while the follow overflow flag is still clear the renormalisation steps run
// twice, once as a check pass that settles the flag. A finish shifts out the
// CODE_BITS bits of low and any pending follow bits, then closes and releases
// the last byte. The multiplier is shift-and-add and the divider yields one
// bit per cycle. Reset, or a restart item, sets low to zero and range to half.
// When the receiver stalls, a finished byte waits in the output register and
// one more in a hold stage; the sequencer pauses only when both are full.
module arithmetic_encoder_low_range #(
    parameter int CODE_BITS   = 16,
    parameter int FOLLOW_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [alr_pkg::KIND_W-1:0]   kind,
    input  logic [alr_pkg::CUM_W-1:0]    cum_upper,
    input  logic [alr_pkg::CUM_W-1:0]    cum_lower,
    input  logic [alr_pkg::CUM_W-1:0]    cum_total,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [alr_pkg::BYTE_W-1:0]   out_byte,
    output logic                         last_of_run,
    output logic                         end_of_stream,
    output logic                         follow_overflow
);

    localparam int CUM_W  = alr_pkg::CUM_W;
    localparam int PROD_W = CODE_BITS + CUM_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    localparam logic [CODE_BITS-1:0]   HALF_VAL   = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0]   QTR_VAL    = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [FOLLOW_BITS-1:0] FOLLOW_MAX = '1;
    localparam logic [FOLLOW_BITS-1:0] FOLLOW_ONE = FOLLOW_BITS'(1);
    localparam logic [CNT_W-1:0]       MUL_LAST   = CNT_W'(CUM_W - 1);
    localparam logic [CNT_W-1:0]       DIV_LAST   = CNT_W'(PROD_W - 1);
    localparam logic [CNT_W-1:0]       FIN_LAST   = CNT_W'(CODE_BITS - 1);
    localparam logic [CNT_W-1:0]       CNT_ONE    = CNT_W'(1);

    alr_pkg::state_t state_reg, state_next;

    logic [CODE_BITS-1:0]     low_reg, low_next;
    logic [CODE_BITS-1:0]     range_reg, range_next;
    logic [FOLLOW_BITS-1:0]   pend_reg, pend_next;
    logic                     ovf_reg, ovf_next;
    logic                     dry_reg, dry_next;
    logic                     fol_bit_reg, fol_bit_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [alr_pkg::KIND_W-1:0] kind_reg, kind_next;

    logic [CUM_W-1:0]         mpl_l_reg, mpl_l_next;
    logic [CUM_W-1:0]         mpl_u_reg, mpl_u_next;
    logic [CUM_W-1:0]         total_reg, total_next;
    logic [PROD_W-1:0]        acc_l_reg, acc_l_next;
    logic [PROD_W-1:0]        acc_u_reg, acc_u_next;
    logic [CUM_W-1:0]         rem_l_reg, rem_l_next;
    logic [CUM_W-1:0]         rem_u_reg, rem_u_next;
    logic [CODE_BITS-1:0]     quo_l_reg, quo_l_next;
    logic [CODE_BITS-1:0]     quo_u_reg, quo_u_next;
    logic [CODE_BITS-1:0]     save_low_reg, save_low_next;
    logic [CODE_BITS-1:0]     save_range_reg, save_range_next;
    logic [FOLLOW_BITS-1:0]   save_pend_reg, save_pend_next;

    alr_pkg::pack_cmd_t       pcmd;
    logic                     taken;
    logic                     in_fire;

    logic [CODE_BITS:0]       sum_lr;
    logic                     range_big;
    logic                     go_low;
    logic                     go_high;
    logic                     is_emit;
    logic [CODE_BITS-1:0]     low_shift;
    logic [CODE_BITS-1:0]     low_fol;
    logic [CODE_BITS-1:0]     low_fol_shift;
    logic [CODE_BITS-1:0]     range_shift;
    logic [PROD_W-1:0]        range_ext;
    logic [PROD_W-1:0]        add_l;
    logic [PROD_W-1:0]        add_u;
    logic [CUM_W:0]           trial_l;
    logic [CUM_W:0]           trial_u;
    logic [CUM_W:0]           diff_l;
    logic [CUM_W:0]           diff_u;
    logic                     ge_l;
    logic                     ge_u;
    logic [CODE_BITS-1:0]     r_new;
    logic [CODE_BITS-1:0]     low_upd;

    assign in_fire = in_valid && in_ready;

    // One renormalisation step.
    assign sum_lr        = {1'b0, low_reg} + {1'b0, range_reg};
    assign range_big     = range_reg > QTR_VAL;
    assign go_low        = sum_lr <= {1'b0, HALF_VAL};
    assign go_high       = !go_low && low_reg[CODE_BITS-1];
    assign is_emit       = go_low || go_high;
    assign low_shift     = {low_reg[CODE_BITS-2:0], 1'b0};
    assign low_fol       = low_reg - QTR_VAL;
    assign low_fol_shift = {low_fol[CODE_BITS-2:0], 1'b0};
    assign range_shift   = {range_reg[CODE_BITS-2:0], 1'b0};

    // Shift-and-add multiply, multiplier taken most significant bit first.
    assign range_ext = {{CUM_W{1'b0}}, range_reg};
    assign add_l = {acc_l_reg[PROD_W-2:0], 1'b0} + (mpl_l_reg[CUM_W-1] ? range_ext : '0);
    assign add_u = {acc_u_reg[PROD_W-2:0], 1'b0} + (mpl_u_reg[CUM_W-1] ? range_ext : '0);

    // Restoring division, one quotient bit per cycle.
    assign trial_l = {rem_l_reg, acc_l_reg[PROD_W-1]};
    assign trial_u = {rem_u_reg, acc_u_reg[PROD_W-1]};
    assign ge_l    = trial_l >= {1'b0, total_reg};
    assign ge_u    = trial_u >= {1'b0, total_reg};
    assign diff_l  = trial_l - {1'b0, total_reg};
    assign diff_u  = trial_u - {1'b0, total_reg};

    assign r_new   = quo_u_reg - quo_l_reg;
    assign low_upd = low_reg + quo_l_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == alr_pkg::KIND_ENC && cum_total != '0)
                    begin
                        state_next = alr_pkg::ST_MUL;
                    end
                    else if (kind == alr_pkg::KIND_FIN)
                    begin
                        state_next = alr_pkg::ST_FIN;
                    end
                end
            end
            alr_pkg::ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = alr_pkg::ST_DIV;
                end
            end
            alr_pkg::ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = alr_pkg::ST_UPD;
                end
            end
            alr_pkg::ST_UPD:
            begin
                state_next = (r_new == '0) ? alr_pkg::ST_IDLE : alr_pkg::ST_REN;
            end
            alr_pkg::ST_REN:
            begin
                if (range_big)
                begin
                    if (!dry_reg)
                    begin
                        state_next = alr_pkg::ST_FLUSH;
                    end
                end
                else if (!dry_reg && is_emit && taken && pend_reg != '0)
                begin
                    state_next = alr_pkg::ST_FOL;
                end
            end
            alr_pkg::ST_FOL:
            begin
                if (taken && pend_reg == FOLLOW_ONE)
                begin
                    state_next = (kind_reg == alr_pkg::KIND_FIN) ? alr_pkg::ST_FIN
                                                                 : alr_pkg::ST_REN;
                end
            end
            alr_pkg::ST_FIN:
            begin
                if (taken)
                begin
                    if (cnt_reg == '0 && pend_reg != '0)
                    begin
                        state_next = alr_pkg::ST_FOL;
                    end
                    else if (cnt_reg == FIN_LAST)
                    begin
                        state_next = alr_pkg::ST_FINL;
                    end
                end
            end
            alr_pkg::ST_FINL:
            begin
                if (taken)
                begin
                    state_next = alr_pkg::ST_FLUSH;
                end
            end
            alr_pkg::ST_FLUSH:
            begin
                if (taken)
                begin
                    state_next = alr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = alr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        pcmd     = '0;
        pcmd.ovf = ovf_reg;
        case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                pcmd.clear = in_valid && kind == alr_pkg::KIND_RST;
            end
            alr_pkg::ST_REN:
            begin
                pcmd.put  = !dry_reg && !range_big && is_emit;
                pcmd.data = go_high;
            end
            alr_pkg::ST_FOL:
            begin
                pcmd.put  = 1'b1;
                pcmd.data = fol_bit_reg;
            end
            alr_pkg::ST_FIN:
            begin
                pcmd.put  = 1'b1;
                pcmd.data = save_low_reg[CODE_BITS-1];
            end
            alr_pkg::ST_FINL:
            begin
                pcmd.fin = 1'b1;
            end
            alr_pkg::ST_FLUSH:
            begin
                pcmd.flush = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        low_next        = low_reg;
        range_next      = range_reg;
        pend_next       = pend_reg;
        ovf_next        = ovf_reg;
        dry_next        = dry_reg;
        fol_bit_next    = fol_bit_reg;
        cnt_next        = cnt_reg;
        kind_next       = kind_reg;
        mpl_l_next      = mpl_l_reg;
        mpl_u_next      = mpl_u_reg;
        total_next      = total_reg;
        acc_l_next      = acc_l_reg;
        acc_u_next      = acc_u_reg;
        rem_l_next      = rem_l_reg;
        rem_u_next      = rem_u_reg;
        quo_l_next      = quo_l_reg;
        quo_u_next      = quo_u_reg;
        save_low_next   = save_low_reg;
        save_range_next = save_range_reg;
        save_pend_next  = save_pend_reg;

        case (state_reg)
            alr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next     = kind;
                    mpl_l_next    = cum_lower;
                    mpl_u_next    = cum_upper;
                    total_next    = cum_total;
                    acc_l_next    = '0;
                    acc_u_next    = '0;
                    cnt_next      = '0;
                    save_low_next = low_reg;
                    if (kind == alr_pkg::KIND_RST)
                    begin
                        low_next   = '0;
                        range_next = HALF_VAL;
                        pend_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            alr_pkg::ST_MUL:
            begin
                acc_l_next = add_l;
                acc_u_next = add_u;
                mpl_l_next = {mpl_l_reg[CUM_W-2:0], 1'b0};
                mpl_u_next = {mpl_u_reg[CUM_W-2:0], 1'b0};
                cnt_next   = (cnt_reg == MUL_LAST) ? '0 : cnt_reg + CNT_ONE;
                rem_l_next = '0;
                rem_u_next = '0;
            end
            alr_pkg::ST_DIV:
            begin
                acc_l_next = {acc_l_reg[PROD_W-2:0], 1'b0};
                acc_u_next = {acc_u_reg[PROD_W-2:0], 1'b0};
                rem_l_next = ge_l ? diff_l[CUM_W-1:0] : trial_l[CUM_W-1:0];
                rem_u_next = ge_u ? diff_u[CUM_W-1:0] : trial_u[CUM_W-1:0];
                quo_l_next = {quo_l_reg[CODE_BITS-2:0], ge_l};
                quo_u_next = {quo_u_reg[CODE_BITS-2:0], ge_u};
                cnt_next   = cnt_reg + CNT_ONE;
            end
            alr_pkg::ST_UPD:
            begin
                if (r_new != '0)
                begin
                    low_next        = low_upd;
                    range_next      = r_new;
                    save_low_next   = low_upd;
                    save_range_next = r_new;
                    save_pend_next  = pend_reg;
                    // The check pass only matters while the overflow flag is clear.
                    dry_next        = !ovf_reg;
                end
            end
            alr_pkg::ST_REN:
            begin
                if (range_big)
                begin
                    if (dry_reg)
                    begin
                        low_next   = save_low_reg;
                        range_next = save_range_reg;
                        pend_next  = save_pend_reg;
                        dry_next   = 1'b0;
                    end
                end
                else if (is_emit)
                begin
                    if (dry_reg)
                    begin
                        low_next   = low_shift;
                        range_next = range_shift;
                        pend_next  = '0;
                    end
                    else if (taken)
                    begin
                        low_next     = low_shift;
                        range_next   = range_shift;
                        fol_bit_next = !go_high;
                    end
                end
                else
                begin
                    if (pend_reg != FOLLOW_MAX)
                    begin
                        pend_next = pend_reg + FOLLOW_ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    low_next   = low_fol_shift;
                    range_next = range_shift;
                end
            end
            alr_pkg::ST_FOL:
            begin
                if (taken)
                begin
                    pend_next = pend_reg - FOLLOW_ONE;
                end
            end
            alr_pkg::ST_FIN:
            begin
                if (taken)
                begin
                    save_low_next = {save_low_reg[CODE_BITS-2:0], 1'b0};
                    cnt_next      = cnt_reg + CNT_ONE;
                    fol_bit_next  = !save_low_reg[CODE_BITS-1];
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alr_pkg::ST_IDLE;
            low_reg   <= '0;
            range_reg <= HALF_VAL;
            pend_reg  <= '0;
            ovf_reg   <= 1'b0;
            dry_reg   <= 1'b0;
            cnt_reg   <= '0;
            kind_reg  <= alr_pkg::KIND_ENC;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            range_reg <= range_next;
            pend_reg  <= pend_next;
            ovf_reg   <= ovf_next;
            dry_reg   <= dry_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fol_bit_reg    <= fol_bit_next;
        mpl_l_reg      <= mpl_l_next;
        mpl_u_reg      <= mpl_u_next;
        total_reg      <= total_next;
        acc_l_reg      <= acc_l_next;
        acc_u_reg      <= acc_u_next;
        rem_l_reg      <= rem_l_next;
        rem_u_reg      <= rem_u_next;
        quo_l_reg      <= quo_l_next;
        quo_u_reg      <= quo_u_next;
        save_low_reg   <= save_low_next;
        save_range_reg <= save_range_next;
        save_pend_reg  <= save_pend_next;
    end

    alr_pack u_pack (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (pcmd),
        .taken           (taken),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .last_of_run     (last_of_run),
        .end_of_stream   (end_of_stream),
        .follow_overflow (follow_overflow)
    );

`ifndef ASSERT_OFF
    a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        range_reg != '0)
        else $error("range register reached zero");

    a_follow_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alr_pkg::ST_FOL) |-> (pend_reg != '0))
        else $error("follow bit emitted with no pending follow count");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && !(in_fire && kind == alr_pkg::KIND_RST)) |=> ovf_reg)
        else $error("overflow flag cleared without a restart");

    a_rem_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alr_pkg::ST_DIV) |-> (rem_l_reg < total_reg && rem_u_reg < total_reg))
        else $error("divider remainder not below the total");
`endif

endmodule
